// ----- hw/rtl/tapid_pkg.sv -----
// ----------------------------------------------------------------------------
// tapid_pkg
// Shared constants, codes and control types of the two-axis PID regulator.
// ----------------------------------------------------------------------------
package tapid_pkg;

  localparam int DATA_WIDTH_DEF  = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int INTEG_WIDTH_DEF = 48;

  // configuration registers are all this wide
  localparam int REG_WIDTH = 32;
  // fractional bits of step_time (Q0.32)
  localparam int DT_FRAC   = 32;
  // operand slice handled by the shared multiplier per cycle
  localparam int CHUNK_W   = 32;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATE = 3'd4;

  localparam logic [REG_WIDTH-1:0] STEP_TIME_RST = 32'd71582788;
  localparam logic [REG_WIDTH-1:0] STEP_RATE_RST = 32'd3932160;

  localparam int FUNC_W = 3;
  localparam logic [FUNC_W-1:0] FN_P       = 3'd0;
  localparam logic [FUNC_W-1:0] FN_I       = 3'd1;
  localparam logic [FUNC_W-1:0] FN_D       = 3'd2;
  localparam logic [FUNC_W-1:0] FN_PID     = 3'd3;
  localparam logic [FUNC_W-1:0] FN_RATE    = 3'd4;
  localparam logic [FUNC_W-1:0] FN_PIR     = 3'd5;
  localparam logic [FUNC_W-1:0] FN_PRELOAD = 3'd6;

  // datapath micro-operations, run in this order per axis
  typedef enum logic [2:0] {
    OP_P,    // kP * e
    OP_INC,  // integral += e * dt
    OP_I,    // kI * integral
    OP_DE,   // (e - last) * rate_hz
    OP_D,    // kD * de
    OP_R     // -kD * rate
  } op_t;

  typedef struct packed {
    logic cap;       // capture input transaction
    logic opnd;      // register operand magnitudes
    logic mul;       // one multiplier slice
    logic rnd;       // round, shift, saturate
    logic apply;     // write result to destination
    logic fin;       // close axis
    logic out_load;  // move result into output register
    op_t  op;
    logic axis;      // 0 x, 1 y
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              two_axis;
  } stat_t;

  function automatic int mul_chunks(int dw, int iw);
    int bsw;
    bsw = (iw > dw + 1) ? iw : dw + 1;
    return (bsw + CHUNK_W - 1) / CHUNK_W;
  endfunction

  function automatic logic op_en(logic [FUNC_W-1:0] func, op_t op);
    logic en;
    case (op)
      OP_P:         en = (func == FN_P) || (func == FN_PID) || (func == FN_PIR);
      OP_INC, OP_I: en = (func == FN_I) || (func == FN_PID) || (func == FN_PIR);
      OP_DE, OP_D:  en = (func == FN_D) || (func == FN_PID);
      OP_R:         en = (func == FN_RATE) || (func == FN_PIR);
      default:      en = 1'b0;
    endcase
    return en;
  endfunction

endpackage

// ----- hw/rtl/tapid_in_if.sv -----
// ----------------------------------------------------------------------------
// tapid_in_if
// Input channel: operation, axis select, errors and measured rates.
// ----------------------------------------------------------------------------
interface tapid_in_if import tapid_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic [FUNC_W-1:0]            func;
  logic                         two_axis;
  logic signed [DATA_WIDTH-1:0] err_x;
  logic signed [DATA_WIDTH-1:0] err_y;
  logic signed [DATA_WIDTH-1:0] rate_x;
  logic signed [DATA_WIDTH-1:0] rate_y;

  modport source (output valid, func, two_axis, err_x, err_y, rate_x, rate_y, input ready);
  modport sink   (input valid, func, two_axis, err_x, err_y, rate_x, rate_y, output ready);
endinterface

// ----- hw/rtl/tapid_out_if.sv -----
// ----------------------------------------------------------------------------
// tapid_out_if
// Result channel: saturated drive values of both axes.
// ----------------------------------------------------------------------------
interface tapid_out_if import tapid_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] drive_x;
  logic signed [DATA_WIDTH-1:0] drive_y;

  modport source (output valid, drive_x, drive_y, input ready);
  modport sink   (input valid, drive_x, drive_y, output ready);
endinterface

// ----- hw/rtl/two_axis_pid_controller.sv -----
// Work per transaction: K enabled micro-ops on each of A axes, A = 1 or 2,
//   K = enabled micro-ops (P 1, I 2, D 2, PID 5, rate 1, PI+rate 4, preload 0),
//   S = 32-bit slices of the wider operand (2 at the default widths).
// One transaction at a time: the next input is taken once the last result is loaded;
//   the shared 32x32 multiplier runs each product as S slices.
// Reset (synchronous, rst_n low): integrators, last errors, gains zero; 60 Hz step; no result.
// ----------------------------------------------------------------------------
// two_axis_pid_controller
// Two-axis Q16.16 PID regulator with saturating integrators and outputs.
// ----------------------------------------------------------------------------
module two_axis_pid_controller import tapid_pkg::*; #(
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int INTEG_WIDTH = INTEG_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  tapid_in_if.sink             in_if,
  tapid_out_if.source          out_if,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_WIDTH-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  tapid_ctrl #(
    .DATA_WIDTH  (DATA_WIDTH),
    .INTEG_WIDTH (INTEG_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tapid_dpath #(
    .DATA_WIDTH  (DATA_WIDTH),
    .FRAC_BITS   (FRAC_BITS),
    .INTEG_WIDTH (INTEG_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_func     (in_if.func),
    .in_two_axis (in_if.two_axis),
    .in_err_x    (in_if.err_x),
    .in_err_y    (in_if.err_y),
    .in_rate_x   (in_if.rate_x),
    .in_rate_y   (in_if.rate_y),
    .out_drive_x (out_if.drive_x),
    .out_drive_y (out_if.drive_y)
  );

endmodule

// ----- hw/rtl/tapid_dpath.sv -----
// ----------------------------------------------------------------------------
// tapid_dpath
// Datapath: config registers, axis state, shared sliced multiplier with
// floor rounding and saturation, term accumulator and output register.
// ----------------------------------------------------------------------------
module tapid_dpath import tapid_pkg::*; #(
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int INTEG_WIDTH = INTEG_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cmd_t                         cmd,
  output stat_t                        stat,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [REG_WIDTH-1:0]         cfg_data,
  input  logic [FUNC_W-1:0]            in_func,
  input  logic                         in_two_axis,
  input  logic signed [DATA_WIDTH-1:0] in_err_x,
  input  logic signed [DATA_WIDTH-1:0] in_err_y,
  input  logic signed [DATA_WIDTH-1:0] in_rate_x,
  input  logic signed [DATA_WIDTH-1:0] in_rate_y,
  output logic signed [DATA_WIDTH-1:0] out_drive_x,
  output logic signed [DATA_WIDTH-1:0] out_drive_y
);

  localparam int DW  = DATA_WIDTH;
  localparam int IW  = INTEG_WIDTH;
  localparam int RW  = (DW > IW) ? DW : IW;
  localparam int BSW = (IW > DW + 1) ? IW : DW + 1;
  localparam int NCH = mul_chunks(DATA_WIDTH, INTEG_WIDTH);
  localparam int BPW = NCH * CHUNK_W;
  localparam int ACW = BPW + CHUNK_W;
  localparam int SW  = DW + 2;

  localparam logic signed [IW-1:0] INTEG_MAX = {1'b0, {(IW-1){1'b1}}};
  localparam logic signed [IW-1:0] INTEG_MIN = {1'b1, {(IW-1){1'b0}}};
  localparam logic signed [DW-1:0] DATA_MAX  = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] DATA_MIN  = {1'b1, {(DW-1){1'b0}}};

  // configuration
  logic signed [REG_WIDTH-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic [REG_WIDTH-1:0]        step_time_r, step_rate_r;

  // axis state
  logic signed [IW-1:0] integ_x_r, integ_y_r;
  logic signed [DW-1:0] last_x_r, last_y_r;

  // captured transaction
  logic [FUNC_W-1:0]    func_r;
  logic                 two_r;
  logic signed [DW-1:0] err_x_r, err_y_r, rate_x_r, rate_y_r;

  // working registers
  logic [CHUNK_W-1:0]   a_mag_r;
  logic [BPW-1:0]       b_pad_r;
  logic                 neg_r;
  logic [ACW-1:0]       acc_r;
  logic signed [RW-1:0] res_r;
  logic signed [DW-1:0] de_r;
  logic signed [SW-1:0] sum_r;
  logic signed [DW-1:0] drv_x_r, drv_y_r;
  logic signed [DW-1:0] out_x_r, out_y_r;

  // axis selection
  logic signed [DW-1:0] err_a, rate_a, last_a;
  logic signed [IW-1:0] integ_a;

  assign err_a   = cmd.axis ? err_y_r   : err_x_r;
  assign rate_a  = cmd.axis ? rate_y_r  : rate_x_r;
  assign last_a  = cmd.axis ? last_y_r  : last_x_r;
  assign integ_a = cmd.axis ? integ_y_r : integ_x_r;

  // operand selection
  logic signed [REG_WIDTH:0] a_s;
  logic signed [BSW-1:0]     b_s;
  logic                      neg_extra;
  logic [REG_WIDTH:0]        a_abs;
  logic [BSW-1:0]            b_abs;

  always_comb begin
    a_s       = {gain_p_r[REG_WIDTH-1], gain_p_r};
    b_s       = BSW'(err_a);
    neg_extra = 1'b0;
    case (cmd.op)
      OP_P: begin
        a_s = {gain_p_r[REG_WIDTH-1], gain_p_r};
        b_s = BSW'(err_a);
      end
      OP_INC: begin
        a_s = {1'b0, step_time_r};
        b_s = BSW'(err_a);
      end
      OP_I: begin
        a_s = {gain_i_r[REG_WIDTH-1], gain_i_r};
        b_s = BSW'(integ_a);
      end
      OP_DE: begin
        a_s = {1'b0, step_rate_r};
        b_s = BSW'(err_a) - BSW'(last_a);
      end
      OP_D: begin
        a_s = {gain_d_r[REG_WIDTH-1], gain_d_r};
        b_s = BSW'(de_r);
      end
      OP_R: begin
        a_s       = {gain_d_r[REG_WIDTH-1], gain_d_r};
        b_s       = BSW'(rate_a);
        neg_extra = 1'b1;
      end
      default: begin
        a_s = {gain_p_r[REG_WIDTH-1], gain_p_r};
        b_s = BSW'(err_a);
      end
    endcase
    a_abs = a_s[REG_WIDTH] ? $unsigned(-a_s) : $unsigned(a_s);
    b_abs = b_s[BSW-1] ? $unsigned(-b_s) : $unsigned(b_s);
  end

  // multiplier slice, most significant slice first
  logic [CHUNK_W-1:0]   b_top;
  logic [2*CHUNK_W-1:0] prod;

  assign b_top = b_pad_r[BPW-1 -: CHUNK_W];
  assign prod  = a_mag_r * b_top;

  // floor rounding of the signed product, shift and magnitude saturation
  logic           rnd_dt;
  logic [ACW:0]   rnd_add, t_sum, t_shift, lim, mag;
  logic [RW-1:0]  res_mag;

  always_comb begin
    rnd_dt  = (cmd.op == OP_INC);
    rnd_add = '0;
    if (neg_r) begin
      rnd_add = rnd_dt ? ((ACW+1)'(1) << DT_FRAC) - (ACW+1)'(1)
                       : ((ACW+1)'(1) << FRAC_BITS) - (ACW+1)'(1);
    end
    t_sum   = {1'b0, acc_r} + rnd_add;
    t_shift = rnd_dt ? (t_sum >> DT_FRAC) : (t_sum >> FRAC_BITS);
    lim     = (rnd_dt ? ((ACW+1)'(1) << (IW-1)) : ((ACW+1)'(1) << (DW-1)))
              - (neg_r ? (ACW+1)'(0) : (ACW+1)'(1));
    mag     = (t_shift > lim) ? lim : t_shift;
    res_mag = mag[RW-1:0];
  end

  // destination updates
  logic signed [IW:0]   integ_sum;
  logic signed [IW-1:0] integ_new, integ_pre;
  logic signed [RW-1:0] pre_ext;
  logic                 pre_ovf;
  logic signed [DW-1:0] sum_sat;

  always_comb begin
    integ_sum = (IW+1)'(integ_a) + (IW+1)'($signed(res_r[IW-1:0]));
    if (integ_sum[IW] != integ_sum[IW-1]) begin
      integ_new = integ_sum[IW] ? INTEG_MIN : INTEG_MAX;
    end else begin
      integ_new = integ_sum[IW-1:0];
    end
    pre_ext = RW'(err_a);
    pre_ovf = !((&pre_ext[RW-1:IW-1]) || !(|pre_ext[RW-1:IW-1]));
    if (pre_ovf) begin
      integ_pre = pre_ext[RW-1] ? INTEG_MIN : INTEG_MAX;
    end else begin
      integ_pre = pre_ext[IW-1:0];
    end
    if (!((&sum_r[SW-1:DW-1]) || !(|sum_r[SW-1:DW-1]))) begin
      sum_sat = sum_r[SW-1] ? DATA_MIN : DATA_MAX;
    end else begin
      sum_sat = sum_r[DW-1:0];
    end
  end

  logic term_op;
  assign term_op = (cmd.op == OP_P) || (cmd.op == OP_I) || (cmd.op == OP_D) ||
                   (cmd.op == OP_R);

  // registers with reset: configuration and axis state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r    <= '0;
      gain_i_r    <= '0;
      gain_d_r    <= '0;
      step_time_r <= STEP_TIME_RST;
      step_rate_r <= STEP_RATE_RST;
      integ_x_r   <= '0;
      integ_y_r   <= '0;
      last_x_r    <= '0;
      last_y_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GAIN_P:    gain_p_r    <= cfg_data;
          CFG_GAIN_I:    gain_i_r    <= cfg_data;
          CFG_GAIN_D:    gain_d_r    <= cfg_data;
          CFG_STEP_TIME: step_time_r <= cfg_data;
          CFG_STEP_RATE: step_rate_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.apply && cmd.op == OP_INC) begin
        if (cmd.axis) integ_y_r <= integ_new;
        else          integ_x_r <= integ_new;
      end
      if (cmd.apply && cmd.op == OP_D) begin
        if (cmd.axis) last_y_r <= err_a;
        else          last_x_r <= err_a;
      end
      if (cmd.fin && func_r == FN_PRELOAD) begin
        if (cmd.axis) begin
          integ_y_r <= integ_pre;
          last_y_r  <= rate_a;
        end else begin
          integ_x_r <= integ_pre;
          last_x_r  <= rate_a;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      func_r   <= in_func;
      two_r    <= in_two_axis;
      err_x_r  <= in_err_x;
      err_y_r  <= in_err_y;
      rate_x_r <= in_rate_x;
      rate_y_r <= in_rate_y;
      sum_r    <= '0;
      drv_y_r  <= '0;
    end
    if (cmd.opnd) begin
      a_mag_r <= a_abs[REG_WIDTH-1:0];
      b_pad_r <= BPW'(b_abs);
      neg_r   <= a_s[REG_WIDTH] ^ b_s[BSW-1] ^ neg_extra;
      acc_r   <= '0;
    end
    if (cmd.mul) begin
      acc_r   <= (acc_r << CHUNK_W) + ACW'(prod);
      b_pad_r <= b_pad_r << CHUNK_W;
    end
    if (cmd.rnd) begin
      res_r <= neg_r ? (~res_mag + RW'(1)) : res_mag;
    end
    if (cmd.apply) begin
      if (term_op) sum_r <= sum_r + SW'($signed(res_r[DW-1:0]));
      if (cmd.op == OP_DE) de_r <= res_r[DW-1:0];
    end
    if (cmd.fin) begin
      if (cmd.axis) drv_y_r <= sum_sat;
      else          drv_x_r <= sum_sat;
      sum_r <= '0;
    end
    if (cmd.out_load) begin
      out_x_r <= drv_x_r;
      out_y_r <= drv_y_r;
    end
  end

  assign stat.func     = func_r;
  assign stat.two_axis = two_r;
  assign out_drive_x   = out_x_r;
  assign out_drive_y   = out_y_r;

endmodule

// ----- hw/rtl/tapid_ctrl.sv -----
// ----------------------------------------------------------------------------
// tapid_ctrl
// Sequencer: walks the micro-operations of each axis, steps the multiplier
// slices and owns both handshakes.
// ----------------------------------------------------------------------------
module tapid_ctrl import tapid_pkg::*; #(
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
  parameter int INTEG_WIDTH = INTEG_WIDTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam int NCH = mul_chunks(DATA_WIDTH, INTEG_WIDTH);
  localparam int KW  = (NCH > 1) ? $clog2(NCH) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEL,
    S_OPND,
    S_MUL,
    S_RND,
    S_APPLY,
    S_FIN,
    S_DONE
  } state_t;

  state_t        state_r, state_nxt;
  op_t           op_r, op_nxt;
  logic          axis_r, axis_nxt;
  logic [KW-1:0] chunk_r, chunk_nxt;
  logic          out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    axis_nxt      = axis_r;
    chunk_nxt     = chunk_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SEL;
          op_nxt    = OP_P;
          axis_nxt  = 1'b0;
        end
      end
      S_SEL: begin
        if (op_en(stat.func, op_r)) begin
          state_nxt = S_OPND;
        end else if (op_r == OP_R) begin
          state_nxt = S_FIN;
        end else begin
          op_nxt = op_t'(op_r + 3'd1);
        end
      end
      S_OPND: begin
        state_nxt = S_MUL;
        chunk_nxt = '0;
      end
      S_MUL: begin
        if (chunk_r == KW'(NCH - 1)) state_nxt = S_RND;
        else chunk_nxt = chunk_r + KW'(1);
      end
      S_RND: state_nxt = S_APPLY;
      S_APPLY: begin
        if (op_r == OP_R) begin
          state_nxt = S_FIN;
        end else begin
          op_nxt    = op_t'(op_r + 3'd1);
          state_nxt = S_SEL;
        end
      end
      S_FIN: begin
        if (!axis_r && stat.two_axis) begin
          axis_nxt  = 1'b1;
          op_nxt    = OP_P;
          state_nxt = S_SEL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // output register frees up in the same cycle it is taken
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_P;
      axis_r      <= 1'b0;
      chunk_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      axis_r      <= axis_nxt;
      chunk_r     <= chunk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.cap      = in_valid && in_ready;
    cmd.opnd     = (state_r == S_OPND);
    cmd.mul      = (state_r == S_MUL);
    cmd.rnd      = (state_r == S_RND);
    cmd.apply    = (state_r == S_APPLY);
    cmd.fin      = (state_r == S_FIN);
    cmd.out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);
    cmd.op       = op_r;
    cmd.axis     = axis_r;
  end

  a_cap_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_SEL))
    else $error("transaction accepted but sequencer did not start");

  a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside completion");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("output register loaded but not presented");

  a_y_only_two_axis: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && axis_r) |-> stat.two_axis)
    else $error("y axis processed for single-axis transaction");

  a_chunk_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (chunk_r <= KW'(NCH - 1)))
    else $error("multiplier slice count out of range");

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Checks the two-axis PID regulator against its own Q16.16 predictor. The
// transactions are driven with random idling and stalls on both sides, and the
// gain and step settings change between phases, extremes among them.
// ----------------------------------------------------------------------------
module testbench import tapid_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = DATA_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int IW = INTEG_WIDTH_DEF;

  // func code with no operation behind it
  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

  localparam logic signed [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [REG_WIDTH-1:0] REG_ONES = '1;
  localparam int RECV_HOLD = 200;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [FUNC_W-1:0]    func;
    logic                 two_axis;
    logic signed [DW-1:0] err_x;
    logic signed [DW-1:0] err_y;
    logic signed [DW-1:0] rate_x;
    logic signed [DW-1:0] rate_y;
  } pid_cmd_t;

  typedef struct {
    logic signed [DW-1:0] drive_x;
    logic signed [DW-1:0] drive_y;
  } drive_pair_t;

  class pid_scoreboard;
    logic signed [DW-1:0]  gain_p, gain_i, gain_d;
    logic [REG_WIDTH-1:0]  step_time, step_rate;
    logic signed [IW-1:0]  integ [2];
    logic signed [DW-1:0]  last_err [2];
    drive_pair_t           drive_q [$];
    int                    errors;

    function new();
      gain_p      = '0;
      gain_i      = '0;
      gain_d      = '0;
      step_time   = STEP_TIME_RST;
      step_rate   = STEP_RATE_RST;
      integ[0]    = '0;
      integ[1]    = '0;
      last_err[0] = '0;
      last_err[1] = '0;
      errors      = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_WIDTH-1:0] val);
      case (idx)
        CFG_GAIN_P:    gain_p = val;
        CFG_GAIN_I:    gain_i = val;
        CFG_GAIN_D:    gain_d = val;
        CFG_STEP_TIME: step_time = val;
        CFG_STEP_RATE: step_rate = val;
        default: ;
      endcase
    endfunction

    function wide_t clamp(wide_t v, int w);
      wide_t hi, lo;
      hi = (wide_t'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // exact product, floor after the shift, then saturate
    function wide_t scaled_mul(wide_t a, wide_t b, bit negate, int sh, int w);
      wide_t prod;
      prod = a * b;
      if (negate) prod = -prod;
      prod = prod >>> sh;
      return clamp(prod, w);
    endfunction

    function logic signed [DW-1:0] axis_drive(logic [FUNC_W-1:0] fn, int ax,
                                              logic signed [DW-1:0] e,
                                              logic signed [DW-1:0] rate);
      wide_t p, i, d, r, inc, de, acc;
      p = 0;
      i = 0;
      d = 0;
      r = 0;
      if (fn == FN_PRELOAD) begin
        acc = wide_t'(e);
        integ[ax]    = acc[IW-1:0];
        last_err[ax] = rate;
        return '0;
      end
      if (fn == FN_UNUSED) return '0;
      if (fn == FN_P || fn == FN_PID || fn == FN_PIR)
        p = scaled_mul(wide_t'(gain_p), wide_t'(e), 1'b0, FB, DW);
      if (fn == FN_I || fn == FN_PID || fn == FN_PIR) begin
        inc = scaled_mul(wide_t'(e), wide_t'({1'b0, step_time}), 1'b0, DT_FRAC, IW);
        acc = clamp(wide_t'(integ[ax]) + inc, IW);
        integ[ax] = acc[IW-1:0];
        i = scaled_mul(wide_t'(gain_i), wide_t'(integ[ax]), 1'b0, FB, DW);
      end
      if (fn == FN_D || fn == FN_PID) begin
        de = scaled_mul(wide_t'(e) - wide_t'(last_err[ax]), wide_t'({1'b0, step_rate}),
                        1'b0, FB, DW);
        d = scaled_mul(wide_t'(gain_d), de, 1'b0, FB, DW);
        last_err[ax] = e;
      end
      if (fn == FN_RATE || fn == FN_PIR)
        r = scaled_mul(wide_t'(gain_d), wide_t'(rate), 1'b1, FB, DW);
      acc = clamp(p + i + d + r, DW);
      return acc[DW-1:0];
    endfunction

    function void note_input(pid_cmd_t c);
      drive_pair_t res;
      res.drive_x = axis_drive(c.func, 0, c.err_x, c.rate_x);
      res.drive_y = c.two_axis ? axis_drive(c.func, 1, c.err_y, c.rate_y) : '0;
      drive_q.push_back(res);
    endfunction

    function void check_result(logic signed [DW-1:0] dx, logic signed [DW-1:0] dy);
      drive_pair_t want;
      if (drive_q.size() == 0) begin
        errors++;
        $error("result transaction with nothing outstanding");
        return;
      end
      want = drive_q.pop_front();
      if (dx !== want.drive_x) begin
        errors++;
        $error("drive_x: expected %0d, got %0d", want.drive_x, dx);
      end
      if (dy !== want.drive_y) begin
        errors++;
        $error("drive_y: expected %0d, got %0d", want.drive_y, dy);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_WIDTH-1:0] cfg_data;

  bit idle_on = 1'b1;
  bit hold_req = 1'b0;

  pid_scoreboard sb = new();

  tapid_in_if  #(.DATA_WIDTH(DW)) in_ch ();
  tapid_out_if #(.DATA_WIDTH(DW)) out_ch ();

  two_axis_pid_controller #(
    .DATA_WIDTH  (DW),
    .FRAC_BITS   (FB),
    .INTEG_WIDTH (IW)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (RECV_HOLD) @(posedge clk);
      end
      out_ch.ready <= !idle_on || ($urandom_range(99) >= 30);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.drive_x, out_ch.drive_y);
  end

  function automatic logic signed [DW-1:0] pick_value();
    logic signed [DW-1:0] v;
    int sel;
    sel = $urandom_range(99);
    if (sel < 15) begin
      case ($urandom_range(3))
        0: v = VAL_MAX;
        1: v = VAL_MIN;
        2: v = '0;
        default: v = '1;
      endcase
    end else if (sel < 65) begin
      // within +/-16.0
      v = DW'($urandom_range(0, 32'h0020_0000)) - DW'(32'h0010_0000);
    end else begin
      v = DW'($urandom());
    end
    return v;
  endfunction

  function automatic pid_cmd_t make_cmd(logic [FUNC_W-1:0] fn, logic both,
                                        logic signed [DW-1:0] ex, logic signed [DW-1:0] ey,
                                        logic signed [DW-1:0] rx, logic signed [DW-1:0] ry);
    pid_cmd_t c;
    c.func     = fn;
    c.two_axis = both;
    c.err_x    = ex;
    c.err_y    = ey;
    c.rate_x   = rx;
    c.rate_y   = ry;
    return c;
  endfunction

  function automatic pid_cmd_t random_cmd();
    int sel;
    logic [FUNC_W-1:0] fn;
    sel = $urandom_range(99);
    if (sel < 10)      fn = FN_PRELOAD;
    else if (sel < 13) fn = FN_UNUSED;
    else               fn = FUNC_W'($urandom_range(FN_P, FN_PIR));
    return make_cmd(fn, $urandom_range(99) < 70, pick_value(), pick_value(),
                    pick_value(), pick_value());
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_WIDTH-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic configure(input logic [REG_WIDTH-1:0] gp, input logic [REG_WIDTH-1:0] gi,
                           input logic [REG_WIDTH-1:0] gd, input logic [REG_WIDTH-1:0] st,
                           input logic [REG_WIDTH-1:0] sr);
    write_reg(CFG_GAIN_P, gp);
    write_reg(CFG_GAIN_I, gi);
    write_reg(CFG_GAIN_D, gd);
    write_reg(CFG_STEP_TIME, st);
    write_reg(CFG_STEP_RATE, sr);
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    logic [REG_WIDTH-1:0] st, sr;
    int hz;
    if ($urandom_range(99) < 25) begin
      st = $urandom_range(1) ? REG_ONES : REG_WIDTH'(1);
      sr = $urandom_range(1) ? REG_ONES : REG_WIDTH'(1);
    end else begin
      hz = $urandom_range(10, 1000);
      sr = REG_WIDTH'(hz) << FB;
      st = REG_ONES / REG_WIDTH'(hz);
    end
    configure(pick_value(), pick_value(), pick_value(), st, sr);
  endtask

  // valid stays high across back-to-back transactions unless an idle gap is drawn
  task automatic send_cmd(input pid_cmd_t c);
    in_ch.valid    <= 1'b1;
    in_ch.func     <= c.func;
    in_ch.two_axis <= c.two_axis;
    in_ch.err_x    <= c.err_x;
    in_ch.err_y    <= c.err_y;
    in_ch.rate_x   <= c.rate_x;
    in_ch.rate_y   <= c.rate_y;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(c);
    if (idle_on && $urandom_range(99) < 30) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.drive_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.func     <= FN_P;
    in_ch.two_axis <= 1'b0;
    in_ch.err_x    <= '0;
    in_ch.err_y    <= '0;
    in_ch.rate_x   <= '0;
    in_ch.rate_y   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // gains only: step settings keep their reset values here
    write_reg(CFG_GAIN_P, 32'h0001_8000);
    write_reg(CFG_GAIN_I, 32'h0000_4000);
    write_reg(CFG_GAIN_D, 32'hFFFF_4000);
    cfg_we <= 1'b0;
    send_cmd(make_cmd(FN_P, 1'b0, VAL_MAX, '0, '0, '0));
    send_cmd(make_cmd(FN_P, 1'b1, VAL_MIN, VAL_MIN, '0, '0));
    send_cmd(make_cmd(FN_I, 1'b1, VAL_MAX, VAL_MIN, '0, '0));
    send_cmd(make_cmd(FN_D, 1'b1, 32'h0001_0000, 32'hFFFE_8000, '0, '0));
    send_cmd(make_cmd(FN_PID, 1'b1, 32'h0003_2000, 32'hFFFF_F000, '0, '0));
    send_cmd(make_cmd(FN_RATE, 1'b1, '0, '0, VAL_MIN, VAL_MAX));
    send_cmd(make_cmd(FN_PIR, 1'b1, 32'h0000_8000, 32'hFFFF_8000, 32'h0002_0000, '1));
    send_cmd(make_cmd(FN_PRELOAD, 1'b1, VAL_MAX, VAL_MIN, VAL_MIN, VAL_MAX));
    // error difference against an extreme previous error
    send_cmd(make_cmd(FN_D, 1'b1, VAL_MAX, VAL_MIN, '0, '0));
    send_cmd(make_cmd(FN_UNUSED, 1'b1, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX));
    send_cmd(make_cmd(FN_PID, 1'b0, 32'h0000_1234, VAL_MAX, '0, VAL_MAX));
    drain();

    configure(VAL_MAX, VAL_MIN, VAL_MIN, REG_ONES, REG_ONES);
    send_cmd(make_cmd(FN_PID, 1'b1, VAL_MAX, VAL_MIN, '0, '0));
    send_cmd(make_cmd(FN_PIR, 1'b1, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX));
    send_cmd(make_cmd(FN_RATE, 1'b1, '0, '0, VAL_MIN, '1));
    send_cmd(make_cmd(FN_I, 1'b1, VAL_MAX, VAL_MIN, '0, '0));
    drain();

    configure(VAL_MIN, VAL_MAX, VAL_MAX, REG_WIDTH'(1), REG_WIDTH'(1));
    send_cmd(make_cmd(FN_PID, 1'b1, VAL_MIN, VAL_MAX, '0, '0));
    send_cmd(make_cmd(FN_PIR, 1'b1, VAL_MAX, '1, VAL_MAX, VAL_MIN));
    send_cmd(make_cmd(FN_D, 1'b1, '1, VAL_MAX, '0, '0));
    drain();

    // zero step settings: integrators hold and the D term vanishes
    configure(32'h0002_0000, 32'h0001_0000, 32'h0001_0000, '0, '0);
    send_cmd(make_cmd(FN_I, 1'b1, VAL_MAX, VAL_MIN, '0, '0));
    send_cmd(make_cmd(FN_D, 1'b1, VAL_MIN, VAL_MAX, '0, '0));
    send_cmd(make_cmd(FN_PID, 1'b1, 32'h0001_0000, 32'hFFFF_0000, '0, '0));
    drain();

    for (int ph = 0; ph < 11; ph++) begin
      random_config();
      idle_on = (ph != 5);
      for (int k = 0; k < 95; k++) begin
        if (ph == 3 && k == 40) hold_req = 1'b1;
        send_cmd(random_cmd());
      end
      drain();
    end
    idle_on = 1'b1;

    repeat (80) @(posedge clk);
    if (sb.errors == 0 && sb.drive_q.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
